[design/rab_pkg.sv]
// ----------------------------------------------------------------------------
// rab_pkg
// Shared types and constants for the ray / box slab test pipeline.
// ----------------------------------------------------------------------------
package rab_pkg;

    localparam int NUM_AXES  = 3;
    // Two slab distances per axis: lane 2*axis is the lower bound, 2*axis+1 the upper.
    localparam int NUM_LANES = 2 * NUM_AXES;

    // Per-item flags that ride alongside the divider lanes.
    typedef struct packed {
        logic [NUM_AXES-1:0] dir_zero;   // direction component is zero
        logic [NUM_AXES-1:0] slab_miss;  // origin outside the slab on that axis
    } rab_side_t;

endpackage

[design/rab_div_pipe.sv]
// ----------------------------------------------------------------------------
// rab_div_pipe
// Multi-lane pipelined restoring divider: floor((un << F) / ud), one quotient
// bit per stage, rounded toward minus infinity by sign and saturated.
// ----------------------------------------------------------------------------
module rab_div_pipe #(
    parameter int W      = 32,
    parameter int F      = 16,
    parameter int LANES  = 6,
    parameter int SIDE_W = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W-1:0]      in_un   [LANES],
    input  logic [W-1:0]      in_ud   [LANES],
    input  logic [LANES-1:0]  in_neg,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [W-2:0]      out_mag [LANES],
    output logic [LANES-1:0]  out_neg,
    output logic [SIDE_W-1:0] out_side
);

    localparam int RW = W + F;       // partial remainder
    localparam int CW = 2 * W + F;   // compare width
    localparam int NS = W - 1;       // quotient bits below saturation

    // input stage
    logic              v0_reg;
    logic [W-1:0]      un0_reg   [LANES];
    logic [W-1:0]      ud0_reg   [LANES];
    logic [LANES-1:0]  neg0_reg;
    logic [SIDE_W-1:0] side0_reg;

    // stage j holds the state before quotient bit W-1-j is decided
    logic              v_reg    [1:W];
    logic [RW-1:0]     rem_reg  [1:W][LANES];
    logic [W-1:0]      ud_reg   [1:W][LANES];
    logic [NS-1:0]     q_reg    [1:W][LANES];
    logic [LANES-1:0]  neg_reg  [1:W];
    logic [LANES-1:0]  ovf_reg  [1:W];
    logic [SIDE_W-1:0] side_reg [1:W];

    logic              out_valid_reg;
    logic [W-2:0]      mag_reg [LANES];
    logic [LANES-1:0]  oneg_reg;
    logic [SIDE_W-1:0] oside_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            un0_reg   <= in_un;
            ud0_reg   <= in_ud;
            neg0_reg  <= in_neg;
            side0_reg <= in_side;
        end
    end

    // overflow check: quotient >= 2^(W-1) saturates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[1] <= 1'b0;
        end else if (en) begin
            v_reg[1] <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[1]  <= neg0_reg;
            side_reg[1] <= side0_reg;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_ovf
        logic [CW-1:0] num_w;
        logic [CW-1:0] lim_w;
        assign num_w = CW'(un0_reg[l]) << F;
        assign lim_w = CW'(ud0_reg[l]) << (W - 1);
        always_ff @(posedge aclk) begin
            if (en) begin
                ovf_reg[1][l] <= (num_w >= lim_w);
                rem_reg[1][l] <= RW'(num_w);
                ud_reg[1][l]  <= ud0_reg[l];
                q_reg[1][l]   <= '0;
            end
        end
    end

    // one quotient bit per stage
    for (genvar j = 1; j < W; j++) begin : g_step
        localparam int K = W - 1 - j;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j+1] <= 1'b0;
            end else if (en) begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[j+1]  <= neg_reg[j];
                ovf_reg[j+1]  <= ovf_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [CW-1:0] sub_w;
            logic [CW-1:0] diff_w;
            logic          ge_w;
            logic [RW-1:0] rem_next;
            logic [NS-1:0] q_next;

            assign sub_w    = CW'(ud_reg[j][l]) << K;
            assign ge_w     = CW'(rem_reg[j][l]) >= sub_w;
            assign diff_w   = CW'(rem_reg[j][l]) - sub_w;
            assign rem_next = ge_w ? RW'(diff_w) : rem_reg[j][l];
            assign q_next   = ge_w ? (q_reg[j][l] | (NS'(1) << K)) : q_reg[j][l];

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j+1][l] <= rem_next;
                    q_reg[j+1][l]   <= q_next;
                    ud_reg[j+1][l]  <= ud_reg[j][l];
                end
            end
        end
    end

    // rounding toward minus infinity for negative quotients, then saturation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            oneg_reg  <= neg_reg[W];
            oside_reg <= side_reg[W];
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_fin
        logic [W-1:0] sum_w;
        logic [W-2:0] mag_next;
        assign sum_w = {1'b0, q_reg[W][l]}
                     + W'(neg_reg[W][l] && (rem_reg[W][l] != '0));
        assign mag_next = (ovf_reg[W][l] || sum_w[W-1]) ? '1 : sum_w[W-2:0];
        always_ff @(posedge aclk) begin
            if (en) begin
                mag_reg[l] <= mag_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_mag   = mag_reg;
    assign out_neg   = oneg_reg;
    assign out_side  = oside_reg;

endmodule

[design/ray_aabb_slab_intersection.sv]
// ----------------------------------------------------------------------------
// ray_aabb_slab_intersection
// Ray versus axis-aligned box slab test, one ray-box pair per clock.
// ----------------------------------------------------------------------------
// A new item is taken every cycle while the result side keeps up; the whole
// pipeline stalls as one when a result waits at m_valid without m_ready.
// The path runs through a register that sorts the box corners, the six-lane
// divider (one quotient bit per stage), and the stages that order the slab
// distances, narrow the [0, max] interval and register the result. Slab
// distances are rounded toward minus infinity and saturated to the largest
// magnitude; a zero direction component passes if the origin lies inside
// that slab (bounds inclusive) and misses otherwise. On a miss both
// distances read zero.
// ----------------------------------------------------------------------------
module ray_aabb_slab_intersection #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_origin_x,
    input  logic signed [COORD_WIDTH-1:0] s_origin_y,
    input  logic signed [COORD_WIDTH-1:0] s_origin_z,
    input  logic signed [COORD_WIDTH-1:0] s_dir_x,
    input  logic signed [COORD_WIDTH-1:0] s_dir_y,
    input  logic signed [COORD_WIDTH-1:0] s_dir_z,
    input  logic signed [COORD_WIDTH-1:0] s_box_min_x,
    input  logic signed [COORD_WIDTH-1:0] s_box_min_y,
    input  logic signed [COORD_WIDTH-1:0] s_box_min_z,
    input  logic signed [COORD_WIDTH-1:0] s_box_max_x,
    input  logic signed [COORD_WIDTH-1:0] s_box_max_y,
    input  logic signed [COORD_WIDTH-1:0] s_box_max_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic        [COORD_WIDTH-2:0] m_t_enter,
    output logic        [COORD_WIDTH-2:0] m_t_exit
);

    localparam int W      = COORD_WIDTH;
    localparam int NAX    = rab_pkg::NUM_AXES;
    localparam int NLN    = rab_pkg::NUM_LANES;
    localparam int SIDE_W = $bits(rab_pkg::rab_side_t);
    localparam logic signed [W-1:0] TMAX = {1'b0, {(W-1){1'b1}}};

    logic m_valid_reg;

    // whole pipe moves when the output register is free or being drained
    logic adv;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ---- stage P: sort corners -------------------------------------------
    logic signed [W-1:0] in_o [NAX];
    logic signed [W-1:0] in_d [NAX];
    logic signed [W-1:0] in_mn [NAX];
    logic signed [W-1:0] in_mx [NAX];

    assign in_o  = '{s_origin_x, s_origin_y, s_origin_z};
    assign in_d  = '{s_dir_x, s_dir_y, s_dir_z};
    assign in_mn = '{s_box_min_x, s_box_min_y, s_box_min_z};
    assign in_mx = '{s_box_max_x, s_box_max_y, s_box_max_z};

    logic                p_valid_reg;
    logic signed [W-1:0] p_o_reg  [NAX];
    logic signed [W-1:0] p_d_reg  [NAX];
    logic signed [W-1:0] p_lo_reg [NAX];
    logic signed [W-1:0] p_hi_reg [NAX];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= s_valid;
        end
    end

    for (genvar a = 0; a < NAX; a++) begin : g_sort
        logic swap_w;
        assign swap_w = in_mn[a] > in_mx[a];
        always_ff @(posedge aclk) begin
            if (adv) begin
                p_o_reg[a]  <= in_o[a];
                p_d_reg[a]  <= in_d[a];
                p_lo_reg[a] <= swap_w ? in_mx[a] : in_mn[a];
                p_hi_reg[a] <= swap_w ? in_mn[a] : in_mx[a];
            end
        end
    end

    // ---- divider operands: magnitudes and quotient signs --------------------
    logic [W-1:0]       div_un  [NLN];
    logic [W-1:0]       div_ud  [NLN];
    logic [NLN-1:0]     div_neg;
    rab_pkg::rab_side_t div_side;

    for (genvar a = 0; a < NAX; a++) begin : g_oper
        logic signed [W:0] dlo_w;
        logic signed [W:0] dhi_w;
        logic        [W:0] nlo_w;
        logic        [W:0] nhi_w;
        logic        [W-1:0] ud_w;

        assign dlo_w = (W+1)'(p_lo_reg[a]) - (W+1)'(p_o_reg[a]);
        assign dhi_w = (W+1)'(p_hi_reg[a]) - (W+1)'(p_o_reg[a]);
        assign nlo_w = -dlo_w;
        assign nhi_w = -dhi_w;
        assign ud_w  = -p_d_reg[a];

        assign div_un[2*a]   = dlo_w[W] ? nlo_w[W-1:0] : dlo_w[W-1:0];
        assign div_un[2*a+1] = dhi_w[W] ? nhi_w[W-1:0] : dhi_w[W-1:0];
        assign div_ud[2*a]   = p_d_reg[a][W-1] ? ud_w : p_d_reg[a];
        assign div_ud[2*a+1] = p_d_reg[a][W-1] ? ud_w : p_d_reg[a];
        assign div_neg[2*a]   = dlo_w[W] ^ p_d_reg[a][W-1];
        assign div_neg[2*a+1] = dhi_w[W] ^ p_d_reg[a][W-1];

        assign div_side.dir_zero[a]  = (p_d_reg[a] == '0);
        assign div_side.slab_miss[a] = (p_o_reg[a] < p_lo_reg[a])
                                    || (p_o_reg[a] > p_hi_reg[a]);
    end

    logic               dq_valid;
    logic [W-2:0]       dq_mag [NLN];
    logic [NLN-1:0]     dq_neg;
    logic [SIDE_W-1:0]  dq_side_bits;
    rab_pkg::rab_side_t dq_side;

    rab_div_pipe #(
        .W      (W),
        .F      (FRAC_BITS),
        .LANES  (NLN),
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p_valid_reg),
        .in_un     (div_un),
        .in_ud     (div_ud),
        .in_neg    (div_neg),
        .in_side   (div_side),
        .out_valid (dq_valid),
        .out_mag   (dq_mag),
        .out_neg   (dq_neg),
        .out_side  (dq_side_bits)
    );

    assign dq_side = rab_pkg::rab_side_t'(dq_side_bits);

    // ---- stage Q1: signed slab distances, ordered per axis -----------------
    logic                q1_valid_reg;
    logic signed [W-1:0] q1_lo_reg [NAX];
    logic signed [W-1:0] q1_hi_reg [NAX];
    rab_pkg::rab_side_t  q1_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1_valid_reg <= 1'b0;
        end else if (adv) begin
            q1_valid_reg <= dq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q1_side_reg <= dq_side;
        end
    end

    for (genvar a = 0; a < NAX; a++) begin : g_order
        logic signed [W-1:0] ta_w;
        logic signed [W-1:0] tb_w;
        assign ta_w = dq_neg[2*a]   ? -{1'b0, dq_mag[2*a]}   : {1'b0, dq_mag[2*a]};
        assign tb_w = dq_neg[2*a+1] ? -{1'b0, dq_mag[2*a+1]} : {1'b0, dq_mag[2*a+1]};
        always_ff @(posedge aclk) begin
            if (adv) begin
                q1_lo_reg[a] <= (ta_w > tb_w) ? tb_w : ta_w;
                q1_hi_reg[a] <= (ta_w > tb_w) ? ta_w : tb_w;
            end
        end
    end

    // ---- stage Q2: narrow [0, TMAX] -----------------------------------------
    logic                q2_valid_reg;
    logic signed [W-1:0] q2_t0_reg;
    logic signed [W-1:0] q2_t1_reg;
    logic                q2_miss_reg;
    logic signed [W-1:0] t0_next;
    logic signed [W-1:0] t1_next;

    always_comb begin
        t0_next = '0;
        t1_next = TMAX;
        for (int a = 0; a < NAX; a++) begin
            if (!q1_side_reg.dir_zero[a]) begin
                if (q1_lo_reg[a] > t0_next) begin
                    t0_next = q1_lo_reg[a];
                end
                if (q1_hi_reg[a] < t1_next) begin
                    t1_next = q1_hi_reg[a];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q2_valid_reg <= 1'b0;
        end else if (adv) begin
            q2_valid_reg <= q1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q2_t0_reg   <= t0_next;
            q2_t1_reg   <= t1_next;
            q2_miss_reg <= |(q1_side_reg.dir_zero & q1_side_reg.slab_miss);
        end
    end

    // ---- stage Q3: result register --------------------------------------------
    logic         m_hit_reg;
    logic [W-2:0] m_t_enter_reg;
    logic [W-2:0] m_t_exit_reg;
    logic         hit_next;

    assign hit_next = !q2_miss_reg && (q2_t0_reg <= q2_t1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= q2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_hit_reg     <= hit_next;
            m_t_enter_reg <= hit_next ? q2_t0_reg[W-2:0] : '0;
            m_t_exit_reg  <= hit_next ? q2_t1_reg[W-2:0] : '0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_hit     = m_hit_reg;
    assign m_t_enter = m_t_enter_reg;
    assign m_t_exit  = m_t_exit_reg;

    // ---- checks ---------------------------------------------------------------
    a_miss_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_t_enter == '0) && (m_t_exit == '0))
        else $error("miss with nonzero distance");

    a_hit_order : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> (m_t_enter <= m_t_exit))
        else $error("hit with entry beyond exit");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !q2_valid_reg && !p_valid_reg)
        else $error("pipeline not empty after reset");

endmodule
